// ----- rtl/dom_pkg.sv -----
// Shared constants, result type and segment decode for the divider ohmmeter display.
// No dependencies; every other file of the block imports this package.
package dom_pkg;

    // Widths fixed by the register and the result fields
    localparam int RREF_W       = 14;
    localparam int TENTHS_W     = 17;
    localparam int SEG_W        = 7;
    localparam int LED_W        = 3;
    localparam int ADC_PORT_W   = 10;
    localparam int ADC_BITS_DEF = 10;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_RREF = 1'b0;
    localparam logic [RREF_W-1:0] RREF_RESET = 14'd100;

    // LED codes, bit2 blue, bit1 green, bit0 red
    localparam logic [LED_W-1:0] LED_OFF   = 3'd0;
    localparam logic [LED_W-1:0] LED_CYAN  = 3'd6;
    localparam logic [LED_W-1:0] LED_WHITE = 3'd7;

    localparam logic [3:0] DIGIT_NINE = 4'd9;

    // One result item
    typedef struct packed {
        logic [TENTHS_W-1:0] resistance_tenths;
        logic [SEG_W-1:0]    upper_segments;
        logic [SEG_W-1:0]    lower_segments;
        logic                decimal_point;
        logic [LED_W-1:0]    led1_color;
        logic [LED_W-1:0]    led2_color;
        logic                buzzer_on;
        logic                over_range;
    } res_t;

    // Active-low seven-segment pattern, bit6 is segment a
    function automatic logic [SEG_W-1:0] seg_of(logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 7'h01;
            4'd1:    s = 7'h4F;
            4'd2:    s = 7'h12;
            4'd3:    s = 7'h06;
            4'd4:    s = 7'h4C;
            4'd5:    s = 7'h24;
            4'd6:    s = 7'h20;
            4'd7:    s = 7'h0F;
            4'd8:    s = 7'h00;
            4'd9:    s = 7'h04;
            default: s = 7'h7F;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/dom_front.sv -----
// Front end: configuration register, input handshake and product/divisor setup.
// Depends on dom_pkg.
module dom_front
    import dom_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF,
    parameter int ENT_W    = (ADC_BITS + RREF_W) + 2 * (ADC_BITS + 7)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    // input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ADC_PORT_W-1:0] adc_code,
    // toward the queue
    output logic                  push_valid,
    input  logic                  push_ready,
    output logic [ENT_W-1:0]      push_data
);

    localparam int NUM_W = ADC_BITS + RREF_W;
    localparam int D_W   = ADC_BITS + 7;
    localparam logic [ADC_BITS:0] FULL = {1'b1, {ADC_BITS{1'b0}}};

    logic [RREF_W-1:0] rref_reg, rref_next;
    logic              f_valid_reg, f_valid_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [D_W-1:0]    dvs_reg, dvs_next;
    logic [D_W-1:0]    lim_reg, lim_next;

    logic [ADC_BITS-1:0] n;
    logic [ADC_BITS:0]   d;
    logic                accept;
    logic                cfg_wr;
    logic                reg_hit;

    // Decode register access
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_RREF);
    assign cfg_wr  = psel && penable && pwrite && reg_hit;
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? PDATA_W'(rref_reg) : '0;

    // Accept when the stage is empty or drains into the queue
    assign push_valid = f_valid_reg;
    assign in_ready   = !f_valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_data  = {num_reg, dvs_reg, lim_reg};

    // Form n*rref, 100*(2^A-n) and 70*(2^A-n)
    assign n = ADC_BITS'(adc_code);
    assign d = FULL - {1'b0, n};

    always_comb
    begin
        rref_next    = cfg_wr ? pwdata[RREF_W-1:0] : rref_reg;
        f_valid_next = f_valid_reg;
        num_next     = num_reg;
        dvs_next     = dvs_reg;
        lim_next     = lim_reg;
        if (accept)
        begin
            f_valid_next = 1'b1;
            num_next     = NUM_W'(n) * NUM_W'(rref_reg);
            dvs_next     = D_W'(d) * D_W'(100);
            lim_next     = D_W'(d) * D_W'(70);
        end
        else if (push_ready)
        begin
            f_valid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rref_reg    <= RREF_RESET;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            rref_reg    <= rref_next;
            f_valid_reg <= f_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        dvs_reg <= dvs_next;
        lim_reg <= lim_next;
    end

endmodule

// ----- rtl/dom_queue.sv -----
// Two-entry queue between the front end and the divider back end.
// Depends on dom_pkg.
module dom_queue
    import dom_pkg::*;
#(
    parameter int W = (ADC_BITS_DEF + RREF_W) + 2 * (ADC_BITS_DEF + 7)
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         push, pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/dom_back.sv -----
// Back end: pipelined restoring divider, digit and flag formatting, output register.
// Depends on dom_pkg.
module dom_back
    import dom_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF,
    parameter int ENT_W    = (ADC_BITS + RREF_W) + 2 * (ADC_BITS + 7)
)
(
    input  logic             clk,
    input  logic             rst_n,
    // from the queue
    input  logic             pop_valid,
    output logic             pop_ready,
    input  logic [ENT_W-1:0] pop_data,
    // result channel
    output logic             out_valid,
    input  logic             out_ready,
    output res_t             res
);

    localparam int NUM_W = ADC_BITS + RREF_W;
    localparam int D_W   = ADC_BITS + 7;

    typedef struct packed {
        logic [D_W-1:0]   rem;
        logic [NUM_W-1:0] dq;
        logic [D_W-1:0]   dvs;
        logic             low;
    } stage_t;

    // One quotient bit per stage: shift in a dividend bit, subtract if it fits
    function automatic stage_t div_step(stage_t s);
        stage_t       o;
        logic [D_W:0] sh;
        logic [D_W:0] df;
        sh = {s.rem, s.dq[NUM_W-1]};
        df = sh - {1'b0, s.dvs};
        o  = s;
        if (sh >= {1'b0, s.dvs})
        begin
            o.rem = df[D_W-1:0];
            o.dq  = {s.dq[NUM_W-2:0], 1'b1};
        end
        else
        begin
            o.rem = sh[D_W-1:0];
            o.dq  = {s.dq[NUM_W-2:0], 1'b0};
        end
        return o;
    endfunction

    stage_t st_reg   [NUM_W];
    stage_t st_next  [NUM_W];
    logic   vld_reg  [NUM_W];
    logic   vld_next [NUM_W];
    logic   out_valid_reg, out_valid_next;
    res_t   res_reg, res_next;

    logic             adv;
    stage_t           s0;
    logic [NUM_W-1:0] e_num;
    logic [D_W-1:0]   e_dvs;
    logic [D_W-1:0]   e_lim;

    logic [NUM_W-1:0] q;
    logic             rem_nz;
    logic             dp, ovr, white;
    logic [9:0]       t10;
    logic [17:0]      m10;
    logic [15:0]      m100;
    logic [6:0]       q10;
    logic [3:0]       q100;
    logic [3:0]       up, lo;

    // Stall the whole pipe while a result waits
    assign adv       = !out_valid_reg || out_ready;
    assign pop_ready = adv;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    // Load the first stage from the queue and flag the low-ohm case
    assign {e_num, e_dvs, e_lim} = pop_data;
    always_comb
    begin
        s0.rem = '0;
        s0.dq  = e_num;
        s0.dvs = e_dvs;
        s0.low = (e_num < NUM_W'(e_lim));
    end

    // Advance the divider stages
    always_comb
    begin
        st_next[0]  = div_step(s0);
        vld_next[0] = pop_valid;
        for (int i = 1; i < NUM_W; i++)
        begin
            st_next[i]  = div_step(st_reg[i-1]);
            vld_next[i] = vld_reg[i-1];
        end
    end

    // Split the quotient into digits and range flags
    assign q      = st_reg[NUM_W-1].dq;
    assign rem_nz = |st_reg[NUM_W-1].rem;
    assign dp     = (q >= NUM_W'(100));
    assign ovr    = (q >= NUM_W'(1000));
    assign white  = (q > NUM_W'(690)) || ((q == NUM_W'(690)) && rem_nz);
    assign t10    = ovr ? 10'd0 : q[9:0];
    assign m10    = 18'(t10) * 18'd205;
    assign m100   = 16'(t10) * 16'd41;
    assign q10    = m10[17:11];
    assign q100   = m100[15:12];

    always_comb
    begin
        if (ovr)
        begin
            up = DIGIT_NINE;
            lo = DIGIT_NINE;
        end
        else if (dp)
        begin
            up = q100;
            lo = 4'(q10 - {q100, 3'b000} - 7'({q100, 1'b0}));
        end
        else
        begin
            up = q10[3:0];
            lo = 4'(t10 - 10'({q10, 3'b000}) - 10'({q10, 1'b0}));
        end
    end

    // Build the result item
    always_comb
    begin
        res_next.resistance_tenths = (|q[NUM_W-1:TENTHS_W]) ? '1 : q[TENTHS_W-1:0];
        res_next.upper_segments    = seg_of(up);
        res_next.lower_segments    = seg_of(lo);
        res_next.decimal_point     = dp;
        if (!dp)
        begin
            res_next.led1_color = LED_OFF;
        end
        else if (white)
        begin
            res_next.led1_color = LED_WHITE;
        end
        else
        begin
            res_next.led1_color = up[LED_W-1:0];
        end
        res_next.led2_color = st_reg[NUM_W-1].low ? LED_CYAN : LED_OFF;
        res_next.buzzer_on  = st_reg[NUM_W-1].low;
        res_next.over_range = ovr;
        out_valid_next      = adv ? vld_reg[NUM_W-1] : out_valid_reg;
    end

    // Hold valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_W; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                for (int i = 0; i < NUM_W; i++)
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NUM_W; i++)
            begin
                st_reg[i] <= st_next[i];
            end
            res_reg <= res_next;
        end
    end

    // A stalled result freezes the pipe
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(vld_reg[NUM_W-1])))
        else $error("divider pipe moved during output stall");

    // Saturated display always shows the point
    a_ovr_dp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.over_range) |-> res_reg.decimal_point)
        else $error("over range without decimal point");

    // Buzzer and cyan LED agree
    a_buzz_led2: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.buzzer_on == (res_reg.led2_color == LED_CYAN)))
        else $error("buzzer and LED 2 disagree");

    // LED 1 dark below 10k
    a_led1_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.decimal_point) |-> (res_reg.led1_color == LED_OFF))
        else $error("LED 1 lit below 10k");

endmodule

// ----- rtl/divider_ohmmeter_display.sv -----
// Top level of the divider ohmmeter display: front end, queue and divider back end.
// Depends on dom_pkg, dom_front, dom_queue and dom_back.
//
// Each adc_code item gives one result item: the resistance in tenths of a kilohm,
// two active-low digit patterns, the decimal point, LED colors, buzzer and over-range
// flag. The block takes one item per clock cycle while the output is not stalled.
// The restoring divider spends one pipeline stage on each of its ADC_BITS + 14
// quotient bits; a result passes the front register, the two-entry queue, these
// stages and the output register in turn. A stalled output holds the divider pipe
// while the queue and front end keep taking items until full.
// The reference resistor sits at byte address 0 of the register port.
module divider_ohmmeter_display
    import dom_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ADC_PORT_W-1:0] adc_code,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TENTHS_W-1:0]   resistance_tenths,
    output logic [SEG_W-1:0]      upper_segments,
    output logic [SEG_W-1:0]      lower_segments,
    output logic                  decimal_point,
    output logic [LED_W-1:0]      led1_color,
    output logic [LED_W-1:0]      led2_color,
    output logic                  buzzer_on,
    output logic                  over_range
);

    localparam int ENT_W = (ADC_BITS + RREF_W) + 2 * (ADC_BITS + 7);

    logic             push_valid, push_ready;
    logic [ENT_W-1:0] push_data;
    logic             pop_valid, pop_ready;
    logic [ENT_W-1:0] pop_data;
    res_t             res;

    dom_front #(
        .ADC_BITS (ADC_BITS),
        .ENT_W    (ENT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .adc_code   (adc_code),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    dom_queue #(
        .W (ENT_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    dom_back #(
        .ADC_BITS (ADC_BITS),
        .ENT_W    (ENT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    // Fan the result item out to its ports
    assign resistance_tenths = res.resistance_tenths;
    assign upper_segments    = res.upper_segments;
    assign lower_segments    = res.lower_segments;
    assign decimal_point     = res.decimal_point;
    assign led1_color        = res.led1_color;
    assign led2_color        = res.led2_color;
    assign buzzer_on         = res.buzzer_on;
    assign over_range        = res.over_range;

endmodule
